@@ src/u2da_pkg.sv @@
// ----------------------------------------------------------------------------
// u2da_pkg: shared types and constants
// Digit, BCD word and character widths used by the converter and the emitter.
// ----------------------------------------------------------------------------
package u2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int POS_W      = $clog2(NUM_DIGITS);
  localparam int STEP_W     = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef digit_t [NUM_DIGITS-1:0] bcd_t;

  // handoff from the converter to the emitter
  typedef struct packed {
    logic valid;
    bcd_t digits;
  } bcd_xfer_t;

endpackage

@@ src/u2da_front.sv @@
// ----------------------------------------------------------------------------
// u2da_front: input side
// Accepts values and holds them in a small FIFO until the converter is free.
// ----------------------------------------------------------------------------
module u2da_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [u2da_pkg::VALUE_W-1:0] in_value,
  output logic                     q_valid,
  input  logic                     q_ready,
  output logic [u2da_pkg::VALUE_W-1:0] q_value
);
  import u2da_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_value  = mem_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

@@ src/u2da_conv.sv @@
// ----------------------------------------------------------------------------
// u2da_conv: binary to BCD converter
// Shift-add-3 over one input bit per cycle; holds the BCD word until taken.
// ----------------------------------------------------------------------------
module u2da_conv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic [u2da_pkg::VALUE_W-1:0] q_value,
  output u2da_pkg::bcd_xfer_t          res,
  input  logic                         res_ready
);
  import u2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              st_r, st_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [VALUE_W-1:0]      bin_r, bin_nxt;
  bcd_t                    bcd_r, bcd_nxt;
  bcd_t                    adj;
  logic [NUM_DIGITS*DIGIT_W-1:0] adj_flat;

  assign q_ready    = (st_r == ST_IDLE);
  assign res.valid  = (st_r == ST_DONE);
  assign res.digits = bcd_r;

  // every digit of 5 or more gets +3 before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= DIGIT_FIVE) ? bcd_r[i] + DIGIT_ADJ : bcd_r[i];
    end
    adj_flat = adj;
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          bin_nxt  = q_value;
          bcd_nxt  = '0;
          step_nxt = STEP_W'(VALUE_W - 1);
          st_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        bcd_nxt  = {adj_flat[NUM_DIGITS*DIGIT_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
  end

endmodule

@@ src/u2da_emit.sv @@
// ----------------------------------------------------------------------------
// u2da_emit: character emitter
// Skips leading zeros and sends digits MSD first through an output register.
// ----------------------------------------------------------------------------
module u2da_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  u2da_pkg::bcd_xfer_t         res,
  output logic                        res_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [u2da_pkg::CHAR_W-1:0] out_ascii_char,
  output logic                        out_last_char
);
  import u2da_pkg::*;

  logic               active_r, active_nxt;
  pos_t               pos_r, pos_nxt;
  bcd_t               dig_r;
  logic               ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  pos_t               lead;
  logic               load, send;

  assign res_ready      = !active_r;
  assign load           = res.valid & !active_r;
  assign send           = active_r & (!ovalid_r | out_ready);
  assign out_valid      = ovalid_r;
  assign out_ascii_char = char_r;
  assign out_last_char  = last_r;

  // highest nonzero digit; zero value starts at the ones digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (res.digits[i] != '0) begin
        lead = POS_W'(i);
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r;
    if (send) begin
      ovalid_nxt = 1'b1;
      if (pos_r == '0) begin
        active_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (load) begin
      active_nxt = 1'b1;
      pos_nxt    = lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (load) begin
      dig_r <= res.digits;
    end
    if (send) begin
      char_r <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_r[pos_r]};
      last_r <= (pos_r == '0);
    end
  end

endmodule

@@ src/uint32_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii_core: 32-bit unsigned to decimal ASCII text
// Converts each value to ASCII digits, MSD first, leading zeros dropped.
// ----------------------------------------------------------------------------
//
//   channel  | ports                               | per transfer
//   ---------+-------------------------------------+---------------------------
//   input    | in_valid/in_ready, in_value         | one 32-bit value
//   output   | out_valid/out_ready, out_ascii_char,| one character, '0'..'9';
//            | out_last_char                       | last_char set on the ones
//
// Flow: u2da_conv loads a value from the queue, runs it through the
// shift-add-3 loop one input bit at a time, then hands the BCD word to the
// emitter; it takes no new value until that word has been taken.
// Characters (1 to 10 per value) leave one per cycle while out_ready is
// high and overlap the next conversion. Reset (rst_n low, synchronous)
// empties the queue and all stages. Either side may stall on its own: the
// input queue absorbs QUEUE_DEPTH values and the output register holds a
// character until it is taken.
module uint32_to_decimal_ascii_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [u2da_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u2da_pkg::CHAR_W-1:0]  out_ascii_char,
  output logic                         out_last_char
);
  import u2da_pkg::*;

  // queue to converter
  logic               q_valid;
  logic               q_ready;
  logic [VALUE_W-1:0] q_value;

  // converter to emitter
  bcd_xfer_t          res;
  logic               res_ready;

  // front: accept and buffer values
  u2da_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_value (q_value)
  );

  // back, part one: binary to BCD, one bit per cycle
  u2da_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_value  (q_value),
    .res      (res),
    .res_ready(res_ready)
  );

  // back, part two: drop leading zeros and send characters
  u2da_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .res_ready     (res_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ascii_char(out_ascii_char),
    .out_last_char (out_last_char)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for uint32_to_decimal_ascii_core
// Sends 32-bit values over the input channel and checks every character
// transfer on the output channel against a digit predictor kept in a
// scoreboard. There is a directed pass over the edge values, then random
// values under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------

// Expected character stream for the converter, filled per input transfer.
class decimal_text_scoreboard;

  typedef struct {
    logic [u2da_pkg::CHAR_W-1:0] ascii_char;
    logic                        last_char;
  } text_char_t;

  text_char_t expected_chars[$];
  int         mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Split a value into decimal digits, MSD first, no leading zeros.
  function void note_value(logic [u2da_pkg::VALUE_W-1:0] value);
    u2da_pkg::digit_t              digits[u2da_pkg::NUM_DIGITS];
    logic [u2da_pkg::VALUE_W-1:0]  rest;
    int                            count;
    text_char_t                    entry;
    rest  = value;
    count = 0;
    do begin
      digits[count] = u2da_pkg::digit_t'(rest % 10);
      rest          = rest / 10;
      count++;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      entry.ascii_char = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_W'(digits[k]);
      entry.last_char  = (k == 0);
      expected_chars.push_back(entry);
    end
  endfunction

  function void check_char(logic [u2da_pkg::CHAR_W-1:0] ascii_char, logic last_char);
    text_char_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected char %0d last %0b", ascii_char, last_char);
      return;
    end
    want = expected_chars.pop_front();
    if (ascii_char !== want.ascii_char || last_char !== want.last_char) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: char exp %0d got %0d, last exp %0b got %0b",
                 want.ascii_char, ascii_char, want.last_char, last_char);
    end
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

endclass

module testbench;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [u2da_pkg::VALUE_W-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [u2da_pkg::CHAR_W-1:0]  out_ascii_char;
  logic                         out_last_char;

  // Percent of cycles in which each side holds off; set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  decimal_text_scoreboard text_sb = new();

  uint32_to_decimal_ascii_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ascii_char(out_ascii_char),
    .out_last_char (out_last_char)
  );

  // 8-unit clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run
  // (about 150 values, each with its conversion, sender gaps and 10 stalled chars).
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: check each character transfer at the edge it happens, then
  // pick the ready for the next cycle. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      text_sb.check_char(out_ascii_char, out_last_char);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One input transfer. An optional gap drops valid first; once valid is up
  // it stays up with a stable value until the block takes it. Valid is left
  // high on return so back-to-back sends keep it up without a glitch.
  task automatic send_value(input logic [u2da_pkg::VALUE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    text_sb.note_value(value);
  endtask

  // Sender holds off until every expected character has come out.
  task automatic drain_output();
    in_valid <= 1'b0;
    while (text_sb.pending() != 0) @(posedge clk);
  endtask

  // Random values spread over all digit counts: full-range words, shifted
  // words for shorter numbers, powers of ten and their neighbors (where the
  // digit count changes), and tiny values.
  function automatic logic [u2da_pkg::VALUE_W-1:0] random_value();
    logic [u2da_pkg::VALUE_W-1:0] pow10;
    int                           exp10;
    pow10 = 1;
    exp10 = $urandom_range(9);
    for (int k = 0; k < exp10; k++) pow10 = pow10 * 10;
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom >> $urandom_range(31);
      2:       return pow10 + $urandom_range(2) - 1;
      default: return $urandom_range(999);
    endcase
  endfunction

  task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      send_value(random_value());
      // a mid-phase pause now and then, with the pipeline fully emptied
      if ($urandom_range(19) == 0) drain_output();
    end
    drain_output();
  endtask

  // Edge values: zero (single '0'), one-digit limit, digit-count boundaries,
  // top bit alone and below it, alternating bit patterns, and the maximum
  // value which gives the longest run of ten characters.
  logic [u2da_pkg::VALUE_W-1:0] directed_values[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
    32'd999999999, 32'd1000000000, 32'd1000000001,
    32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4000000000, 32'd0, 32'hFFFF_FFFF
  };

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed values, no idling on either side
    foreach (directed_values[i]) send_value(directed_values[i]);
    drain_output();

    // random phases: free-running, sender idle, receiver stalling, both
    run_random_phase(30, 0, 0);
    run_random_phase(30, 57, 0);
    run_random_phase(30, 0, 57);
    run_random_phase(30, 20, 20);

    // nothing further should come out once the queue is empty
    repeat (80) @(posedge clk);

    if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
